/* rtl/smm_pkg.sv */
// ----------------------------------------------------------------------------
// smm_pkg
// Shared sizes and request codes for the square matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

    // Matrix geometry
    localparam int MAX_DIM = 8;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;

    // Data widths
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 32;
    localparam int DIM_W   = 4;

    // Dimension after reset
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // Request codes
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

endpackage

`default_nettype wire

/* rtl/square_matrix_multiply_top.sv */
// ----------------------------------------------------------------------------
// square_matrix_multiply_top
// Loads A and B into two RAMs and streams out the product A*B row by row.
// ----------------------------------------------------------------------------
// Load request: one per cycle while not busy, written to RAM at the accepting edge, no result.
// Start request: busy through run and drain, dimension capped at 8; the
//   issue counter reads one A and one B entry per cycle from the RAM read ports.
// Each result strobes once the last read of its dot product has passed the RAM
//   read, product and output registers; the receiver cannot hold results off.
// Reset: dimension returns to 8; matrix RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply_top
    import smm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               req_type,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic signed [DATA_W-1:0] element_value,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [DIM_W-1:0]         cfg_data,
    output logic                          result_valid,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic signed [PROD_W-1:0]      product_value,
    output logic                          last_result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first_k;
        logic             last_k;
        logic             final_elem;
    } tag_t;

    state_t            state_reg, state_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [IDX_W-1:0]  dlast_reg, dlast_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;

    logic              accept;
    logic              load_a;
    logic              load_b;
    logic              start_run;
    logic [DIM_W-1:0]  dim_used;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [DATA_W-1:0] rd_data_a;
    logic [DATA_W-1:0] rd_data_b;

    logic              rd_valid_reg;
    tag_t              rd_tag_reg;
    tag_t              issue_tag;
    logic              prod_valid_reg;
    tag_t              prod_tag_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] sum;

    logic              result_valid_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [PROD_W-1:0] out_value_reg;
    logic              out_last_reg;

    // Decode the request
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign dim_used  = (dim_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_reg;

    always_comb
    begin
        load_a    = 1'b0;
        load_b    = 1'b0;
        start_run = 1'b0;
        unique case (req_type)
            REQ_LOAD_A: load_a    = accept;
            REQ_LOAD_B: load_b    = accept;
            REQ_START:  start_run = accept && (dim_used != '0);
            default:    ;
        endcase
    end

    // Configuration write
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dim_reg <= cfg_data;
        end
    end

    // Matrix stores
    assign wr_addr   = {row_index, col_index};
    assign rd_addr_a = {i_reg, k_reg};
    assign rd_addr_b = {k_reg, j_reg};

    smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .clk     (clk),
        .wr_en   (load_a),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .clk     (clk),
        .wr_en   (load_b),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Advance the i/j/k read sequencer
    always_comb
    begin
        state_next = state_reg;
        dlast_next = dlast_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_run)
                begin
                    state_next = ST_RUN;
                    dlast_next = IDX_W'(dim_used - DIM_W'(1));
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (k_reg == dlast_reg)
                begin
                    k_next = '0;
                    if (j_reg == dlast_reg)
                    begin
                        j_next = '0;
                        if (i_reg == dlast_reg)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !prod_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dlast_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dlast_reg <= dlast_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Tag the read with its product position
    always_comb
    begin
        issue_tag.row        = i_reg;
        issue_tag.col        = j_reg;
        issue_tag.first_k    = (k_reg == '0);
        issue_tag.last_k     = (k_reg == dlast_reg);
        issue_tag.final_elem = (k_reg == dlast_reg) && (j_reg == dlast_reg)
                               && (i_reg == dlast_reg);
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= (state_reg == ST_RUN);
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Carry tags, multiply the read data
    always_ff @(posedge clk)
    begin
        rd_tag_reg   <= issue_tag;
        prod_tag_reg <= rd_tag_reg;
        prod_reg     <= PROD_W'($signed(rd_data_a) * $signed(rd_data_b));
    end

    // Accumulate the dot product, wrapping at 32 bits
    assign sum = (prod_tag_reg.first_k ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            acc_reg <= sum;
        end
        if (prod_valid_reg && prod_tag_reg.last_k)
        begin
            out_row_reg   <= prod_tag_reg.row;
            out_col_reg   <= prod_tag_reg.col;
            out_value_reg <= sum;
            out_last_reg  <= prod_tag_reg.final_elem;
        end
    end

    // Strobe each finished element for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= prod_valid_reg && prod_tag_reg.last_k;
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_value_reg;
    assign last_result   = result_valid_reg && out_last_reg;

    // Checks
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a run");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_run |=> (state_reg == ST_RUN))
        else $error("start request did not begin a run");

    a_read_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_RUN))
        else $error("matrix read outside the run state");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(load_a || load_b))
        else $error("store written during a run");

endmodule

`default_nettype wire

/* rtl/smm_ram.sv */
// ----------------------------------------------------------------------------
// smm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for square_matrix_multiply_top. A short directed table
// hits value extremes, the corner indexes, the unused request code and the
// zero and small dimensions. Random phases then reload the stores and start
// products at varying dimensions. Every accepted request but a typed start
// feeds an in-bench matrix predictor; each product strobe is checked in order.
// ----------------------------------------------------------------------------

module tb_top;
    import smm_pkg::*;

    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS  = 250;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         IDLE_PCT      = 32;
    localparam int         TABLE_ROWS    = 17;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROD_W-1:0] value;
        logic              last;
    } product_t;

    typedef struct packed {
        logic [DIM_W-1:0]  dim;
        logic [1:0]        req;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [PROD_W-1:0] product;
    } table_row_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     start         = 1'b0;
    logic                     busy;
    logic [1:0]               req_type      = REQ_LOAD_A;
    logic [IDX_W-1:0]         row_index     = '0;
    logic [IDX_W-1:0]         col_index     = '0;
    logic signed [DATA_W-1:0] element_value = '0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [DIM_W-1:0]         cfg_data      = '0;
    logic                     result_valid;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product_value;
    logic                     last_result;

    // Predictor state: own copy of the dimension and both matrix stores
    logic [DIM_W-1:0]         dimension_reg = DIM_RESET;
    logic signed [DATA_W-1:0] left_store  [DEPTH];
    logic signed [DATA_W-1:0] right_store [DEPTH];
    bit                       left_written  [DEPTH];
    bit                       right_written [DEPTH];
    product_t                 pending_products [$];

    int mismatch_count = 0;
    int idle_pct       = IDLE_PCT;

    // Directed requests; typed rows carry the single 1x1 product
    table_row_t directed_table [TABLE_ROWS] = '{
        '{4'd1, REQ_LOAD_A, 3'd0, 3'd0, 16'h8000, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_LOAD_B, 3'd0, 3'd0, 16'h8000, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_START,  3'd0, 3'd0, 16'h0000, 1'b1, 32'h4000_0000},
        '{4'd1, REQ_LOAD_A, 3'd7, 3'd7, 16'h7FFF, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_LOAD_B, 3'd7, 3'd0, 16'hFFFF, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_UNUSED, 3'd5, 3'd2, 16'h5555, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_LOAD_A, 3'd0, 3'd0, 16'h7FFF, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_LOAD_B, 3'd0, 3'd0, 16'h7FFF, 1'b0, 32'h0000_0000},
        '{4'd1, REQ_START,  3'd7, 3'd7, 16'hFFFF, 1'b1, 32'h3FFF_0001},
        '{4'd0, REQ_START,  3'd0, 3'd0, 16'h0000, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_LOAD_A, 3'd0, 3'd1, 16'h8000, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_LOAD_A, 3'd1, 3'd0, 16'h0001, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_LOAD_A, 3'd1, 3'd1, 16'hFFFF, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_LOAD_B, 3'd0, 3'd1, 16'h8000, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_LOAD_B, 3'd1, 3'd0, 16'h8000, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_LOAD_B, 3'd1, 3'd1, 16'h7FFF, 1'b0, 32'h0000_0000},
        '{4'd2, REQ_START,  3'd2, 3'd6, 16'hAAAA, 1'b0, 32'h0000_0000}
    };

    square_matrix_multiply_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last_result   (last_result)
    );

    always #1 clk = ~clk;

    // Bias element values toward the signed extremes
    function automatic logic [DATA_W-1:0] random_element();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Append one expected product at the tail of the queue
    task automatic queue_product(input product_t entry);
        pending_products.insert(pending_products.size(), entry);
    endtask

    // Update the stores on a load; queue the whole product on a start
    task automatic apply_request(input logic [1:0] req, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col,
                                 input logic signed [DATA_W-1:0] value);
        int                dim;
        int                a;
        int                b;
        logic [PROD_W-1:0] acc;
        product_t          entry;
        case (req)
            REQ_LOAD_A:
            begin
                left_store[row * MAX_DIM + col]    = value;
                left_written[row * MAX_DIM + col]  = 1'b1;
            end
            REQ_LOAD_B:
            begin
                right_store[row * MAX_DIM + col]   = value;
                right_written[row * MAX_DIM + col] = 1'b1;
            end
            REQ_START:
            begin
                dim = (dimension_reg > MAX_DIM) ? MAX_DIM : int'(dimension_reg);
                for (int i = 0; i < dim; i++)
                begin
                    for (int j = 0; j < dim; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < dim; k++)
                        begin
                            a   = left_store[i * MAX_DIM + k];
                            b   = right_store[k * MAX_DIM + j];
                            acc = acc + PROD_W'(a * b);
                        end
                        entry.row   = IDX_W'(i);
                        entry.col   = IDX_W'(j);
                        entry.value = acc;
                        entry.last  = (i == dim - 1) && (j == dim - 1);
                        queue_product(entry);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Drive one request after a random gap and hold it until accepted
    task automatic send_request(input logic [1:0] req, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value,
                                input logic typed, input logic [PROD_W-1:0] typed_product);
        product_t entry;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        req_type      <= req;
        row_index     <= row;
        col_index     <= col;
        element_value <= value;
        do
            @(posedge clk);
        while (busy);
        if (typed)
        begin
            entry = '{IDX_W'(0), IDX_W'(0), typed_product, 1'b1};
            queue_product(entry);
        end
        else
        begin
            apply_request(req, row, col, value);
        end
    endtask

    // Drop start and wait until every product is out and the block is quiet
    task automatic wait_idle();
        start <= 1'b0;
        do
        begin
            while (pending_products.size() != 0 || busy)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (pending_products.size() != 0 || busy);
    endtask

    // Write the dimension register while the block is idle
    task automatic set_dimension(input logic [DIM_W-1:0] dim);
        wait_idle();
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= dim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        dimension_reg  = dim;
    endtask

    task automatic report_field(input string name, input logic [PROD_W-1:0] want,
                                input logic [PROD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check each product strobe against the oldest expected product
    always @(posedge clk)
    begin
        product_t want;
        if (rst_n && result_valid)
        begin
            if (pending_products.size() == 0)
            begin
                $display("%0t: product expected none actual (%0d,%0d) %h last %b", $time,
                         out_row, out_col, product_value, last_result);
                mismatch_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                report_field("out_row", PROD_W'(want.row), PROD_W'(out_row));
                report_field("out_col", PROD_W'(want.col), PROD_W'(out_col));
                report_field("product_value", want.value, product_value);
                report_field("last_result", PROD_W'(want.last), PROD_W'(last_result));
            end
        end
    end

    // Stimulus: directed table, then random load-and-multiply phases
    initial
    begin
        int               phase;
        int               random_items;
        int               used;
        int               pick;
        logic [DIM_W-1:0] dim;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        phase        = 0;
        random_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int n = 0; n < TABLE_ROWS; n++)
        begin
            if (directed_table[n].dim != dimension_reg)
                set_dimension(directed_table[n].dim);
            send_request(directed_table[n].req, directed_table[n].row, directed_table[n].col,
                         directed_table[n].value, directed_table[n].typed,
                         directed_table[n].product);
        end

        // Random phases: fill unwritten entries, then loads, noise and starts
        while (random_items < RANDOM_ITEMS)
        begin
            idle_pct = (phase >= 2 && phase < 6) ? 0 : IDLE_PCT;
            case (phase)
                0:       dim = 4'd15;
                1:       dim = DIM_RESET;
                default:
                begin
                    pick = $urandom_range(19);
                    if (pick == 0)
                        dim = 4'd0;
                    else if (pick == 1)
                        dim = DIM_W'($urandom_range(15, 9));
                    else if (pick < 4)
                        dim = DIM_RESET;
                    else
                        dim = DIM_W'($urandom_range(7, 1));
                end
            endcase
            set_dimension(dim);
            used = (dim > MAX_DIM) ? MAX_DIM : int'(dim);

            for (int i = 0; i < used; i++)
            begin
                for (int j = 0; j < used; j++)
                begin
                    if (!left_written[i * MAX_DIM + j])
                    begin
                        send_request(REQ_LOAD_A, IDX_W'(i), IDX_W'(j), random_element(), 1'b0, '0);
                        random_items++;
                    end
                    if (!right_written[i * MAX_DIM + j])
                    begin
                        send_request(REQ_LOAD_B, IDX_W'(i), IDX_W'(j), random_element(), 1'b0, '0);
                        random_items++;
                    end
                end
            end

            repeat ($urandom_range(3, 1))
            begin
                repeat ($urandom_range(8, 0))
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_request(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                                     DATA_W'($urandom), 1'b0, '0);
                    end
                    else
                    begin
                        if (used > 0 && $urandom_range(3) != 0)
                        begin
                            r = IDX_W'($urandom_range(used - 1, 0));
                            c = IDX_W'($urandom_range(used - 1, 0));
                        end
                        else
                        begin
                            r = IDX_W'($urandom);
                            c = IDX_W'($urandom);
                        end
                        send_request($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A, r, c,
                                     random_element(), 1'b0, '0);
                        random_items++;
                    end
                end
                send_request(REQ_START, IDX_W'($urandom), IDX_W'($urandom),
                             DATA_W'($urandom), 1'b0, '0);
                random_items++;
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("square_matrix_multiply_top verification clean");
        else
            $display("square_matrix_multiply_top verification failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("square_matrix_multiply_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/square_matrix_multiply_top.sv
tb/tb_top.sv
